/* src/gf2_polynomial_arith_unit_core_defines.svh */
// assertion macros for the gf2 polynomial arithmetic unit
// used by gf2_polynomial_arith_unit_core, relies on clk and rst_n in scope
`ifndef GF2_POLYNOMIAL_ARITH_UNIT_CORE_DEFINES_SVH
`define GF2_POLYNOMIAL_ARITH_UNIT_CORE_DEFINES_SVH

// same-cycle implication under reset
`define GPAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define GPAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gf2pau_pkg.sv */
// shared types and constants for the gf2 polynomial arithmetic unit
// no dependencies
package gf2pau_pkg;

  localparam int OP_W   = 2;
  localparam int OPND_W = 32;
  localparam int MAIN_W = 63;
  localparam int REM_W  = 32;
  localparam int DEG_W  = 6;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_MUL = 2'd1;
  localparam logic [OP_W-1:0] OP_DIV = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [MAIN_W-1:0] main_result;
    logic [REM_W-1:0]  remainder;
    logic [DEG_W-1:0]  result_degree;
    logic              divide_by_zero;
  } out_item_t;

  // control for one step of the shift-and-xor unit
  typedef struct packed {
    logic is_div;
    logic a_bit;
    logic b_bit;
  } step_ctl_t;

endpackage

/* src/gf2pau_step.sv */
// one step of the shared shift-and-xor unit: carry-less multiply or long division
// depends on gf2pau_pkg
module gf2pau_step #(
  parameter int W = 32
) (
  input  gf2pau_pkg::step_ctl_t  ctl_i,
  input  logic [W-1:0]           a_i,
  input  logic [W-1:0]           b_i,
  input  logic [$clog2(W)-1:0]   db_i,
  input  logic [2*W-2:0]         acc_i,
  input  logic [W-1:0]           rem_i,
  output logic [2*W-2:0]         acc_o,
  output logic [W-1:0]           rem_o
);

  localparam int PW = 2 * W - 1;

  logic [W-1:0] r_sh;
  logic         hit;

  // bring down the next dividend bit, subtract divisor when its leading term is hit
  assign r_sh = {rem_i[W-2:0], ctl_i.a_bit};
  assign hit  = r_sh[db_i];

  always_comb begin
    if (ctl_i.is_div) begin
      acc_o = {acc_i[PW-2:0], hit};
      rem_o = hit ? (r_sh ^ b_i) : r_sh;
    end else begin
      acc_o = {acc_i[PW-2:0], 1'b0} ^ (ctl_i.b_bit ? PW'(a_i) : '0);
      rem_o = rem_i;
    end
  end

endmodule

/* src/gf2_polynomial_arith_unit_core.sv */
// gf2 polynomial add, carry-less multiply and long division, W = OPERAND_WIDTH
// each item first runs a degree scan, one bit per cycle; multiply and divide (nonzero divisor)
// then run the shift-and-xor unit, while add, unused op and zero divisor go straight to done
// one item at a time: next input taken once the result is in the output register
// a finished result waits in the done state while out_stall holds the output register full
// reset: synchronous active-low rst_n, idles with no result pending
module gf2_polynomial_arith_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gf2pau_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gf2pau_pkg::out_item_t  out_data
);

  `include "gf2_polynomial_arith_unit_core_defines.svh"

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W - 1;
  localparam int CW = $clog2(W);
  localparam int MW = gf2pau_pkg::MAIN_W;
  localparam int RW = gf2pau_pkg::REM_W;
  localparam int DW = gf2pau_pkg::DEG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [gf2pau_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [W-1:0]                  a_r, a_nxt;
  logic [W-1:0]                  b_r, b_nxt;
  logic [CW-1:0]                 da_r, da_nxt;
  logic [CW-1:0]                 db_r, db_nxt;
  logic [CW-1:0]                 dx_r, dx_nxt;
  logic [PW-1:0]                 acc_r, acc_nxt;
  logic [W-1:0]                  rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gf2pau_pkg::out_item_t         out_data_r, out_data_nxt;

  gf2pau_pkg::step_ctl_t         step_ctl;
  logic [PW-1:0]                 step_acc;
  logic [W-1:0]                  step_rem;
  logic [W-1:0]                  x_w;
  logic                          a_nz, b_nz;
  gf2pau_pkg::out_item_t         res;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign x_w  = a_r ^ b_r;
  assign a_nz = (a_r != '0);
  assign b_nz = (b_r != '0);

  assign step_ctl.is_div = (op_r == gf2pau_pkg::OP_DIV);
  assign step_ctl.a_bit  = a_r[cnt_r];
  assign step_ctl.b_bit  = b_r[cnt_r];

  gf2pau_step #(
    .W (W)
  ) u_step (
    .ctl_i (step_ctl),
    .a_i   (a_r),
    .b_i   (b_r),
    .db_i  (db_r),
    .acc_i (acc_r),
    .rem_i (rem_r),
    .acc_o (step_acc),
    .rem_o (step_rem)
  );

  // result assembly from the finished accumulators and scanned degrees
  always_comb begin
    res = '0;
    unique case (op_r)
      gf2pau_pkg::OP_ADD: begin
        res.main_result   = MW'(x_w);
        res.result_degree = DW'(dx_r);
      end
      gf2pau_pkg::OP_MUL: begin
        res.main_result = MW'(acc_r);
        // leading terms never cancel over gf2
        if (a_nz && b_nz) begin
          res.result_degree = DW'(da_r) + DW'(db_r);
        end
      end
      gf2pau_pkg::OP_DIV: begin
        if (!b_nz) begin
          res.divide_by_zero = 1'b1;
        end else begin
          res.main_result = MW'(acc_r);
          res.remainder   = RW'(rem_r);
          if (a_nz && (da_r >= db_r)) begin
            res.result_degree = DW'(da_r) - DW'(db_r);
          end
        end
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    dx_nxt        = dx_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          a_nxt     = in_data.operand_a[W-1:0];
          b_nxt     = in_data.operand_b[W-1:0];
          cnt_nxt   = '0;
          da_nxt    = '0;
          db_nxt    = '0;
          dx_nxt    = '0;
          acc_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // last set bit found going upwards is the degree
        if (a_r[cnt_r]) da_nxt = cnt_r;
        if (b_r[cnt_r]) db_nxt = cnt_r;
        if (x_w[cnt_r]) dx_nxt = cnt_r;
        if (cnt_r == CW'(W - 1)) begin
          if ((op_r == gf2pau_pkg::OP_MUL) || (op_r == gf2pau_pkg::OP_DIV && b_nz)) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RUN: begin
        acc_nxt = step_acc;
        rem_nxt = step_rem;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    dx_r       <= dx_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  `GPAU_ASSERT_NEXT(a_accept_starts_scan, in_valid && !in_stall,
                    state_r == S_SCAN && cnt_r == '0, "transfer did not start the degree scan")
  `GPAU_ASSERT_NOW(a_rem_below_divisor, state_r == S_RUN && op_r == gf2pau_pkg::OP_DIV,
                   (rem_r >> db_r) == '0, "partial remainder reached divisor degree")
  `GPAU_ASSERT_NOW(a_dz_clears_result, out_valid && out_data.divide_by_zero,
                   out_data.main_result == '0 && out_data.remainder == '0 &&
                   out_data.result_degree == '0, "divide by zero result not cleared")
  `GPAU_ASSERT_NEXT(a_done_delivers, state_r == S_DONE && !(out_valid && out_stall),
                    out_valid && state_r == S_IDLE, "finished item not moved to output")

endmodule

/* bench/testbench.sv */
// self-checking bench for gf2_polynomial_arith_unit_core: add, carry-less multiply, long division
// needs gf2pau_pkg and the core; holds its own polynomial predictor in a small scoreboard class
`timescale 1ns / 1ps

module testbench;

  localparam logic [gf2pau_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 2 * gf2pau_pkg::OPND_W + 16;

  class gf2_result_board;
    gf2pau_pkg::out_item_t awaited_results[$];
    int unsigned mismatch_count;

    function logic [gf2pau_pkg::DEG_W-1:0] top_degree(logic [gf2pau_pkg::MAIN_W-1:0] p);
      logic [gf2pau_pkg::DEG_W-1:0] d;
      d = '0;
      for (int k = 0; k < gf2pau_pkg::MAIN_W; k++) begin
        if (p[k]) d = gf2pau_pkg::DEG_W'(k);
      end
      return d;
    endfunction

    function gf2pau_pkg::out_item_t poly_result(gf2pau_pkg::in_item_t req);
      gf2pau_pkg::out_item_t r;
      logic [63:0] acc;
      logic [63:0] rem;
      int db;
      r = '0;
      acc = '0;
      rem = '0;
      case (req.op)
        gf2pau_pkg::OP_ADD: acc = {32'b0, req.operand_a ^ req.operand_b};
        gf2pau_pkg::OP_MUL: begin
          for (int k = 0; k < gf2pau_pkg::OPND_W; k++) begin
            if (req.operand_b[k]) acc ^= {32'b0, req.operand_a} << k;
          end
        end
        gf2pau_pkg::OP_DIV: begin
          if (req.operand_b == '0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            db = int'(top_degree({31'b0, req.operand_b}));
            rem = {32'b0, req.operand_a};
            for (int i = gf2pau_pkg::OPND_W - 1; i >= db; i--) begin
              if (rem[i]) begin
                rem ^= {32'b0, req.operand_b} << (i - db);
                acc[i - db] = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      r.main_result = acc[gf2pau_pkg::MAIN_W-1:0];
      r.remainder = rem[gf2pau_pkg::REM_W-1:0];
      r.result_degree = top_degree(r.main_result);
      return r;
    endfunction

    function void note_request(gf2pau_pkg::in_item_t req);
      awaited_results.push_back(poly_result(req));
    endfunction

    function void check_result(gf2pau_pkg::out_item_t got);
      gf2pau_pkg::out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing awaited: %h", got);
        mismatch_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.main_result !== want.main_result) begin
        $error("main_result: expected %h, actual %h", want.main_result, got.main_result);
        mismatch_count++;
      end
      if (got.remainder !== want.remainder) begin
        $error("remainder: expected %h, actual %h", want.remainder, got.remainder);
        mismatch_count++;
      end
      if (got.result_degree !== want.result_degree) begin
        $error("result_degree: expected %0d, actual %0d", want.result_degree,
               got.result_degree);
        mismatch_count++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $error("divide_by_zero: expected %b, actual %b", want.divide_by_zero,
               got.divide_by_zero);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  gf2pau_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  gf2pau_pkg::out_item_t out_data;

  int send_idle_pct;
  int recv_stall_pct;
  int unsigned cycle_count;
  gf2_result_board board;

  gf2_polynomial_arith_unit_core #(.OPERAND_WIDTH(gf2pau_pkg::OPND_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check on transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(input logic [gf2pau_pkg::OP_W-1:0] op,
                              input logic [gf2pau_pkg::OPND_W-1:0] a,
                              input logic [gf2pau_pkg::OPND_W-1:0] b);
    gf2pau_pkg::in_item_t req;
    req.op = op;
    req.operand_a = a;
    req.operand_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(req);
  endtask

  // mix of dense, sparse, low-degree and extreme polynomials
  function automatic logic [gf2pau_pkg::OPND_W-1:0] pick_poly();
    logic [gf2pau_pkg::OPND_W-1:0] v;
    int unsigned deg;
    v = $urandom();
    case ($urandom_range(11))
      0: v = '0;
      1: v = '1;
      2: v = gf2pau_pkg::OPND_W'(1) << $urandom_range(gf2pau_pkg::OPND_W - 1);
      3: v = v & $urandom() & $urandom();
      4, 5, 6: begin
        deg = $urandom_range(gf2pau_pkg::OPND_W - 1);
        v = v & gf2pau_pkg::OPND_W'((64'd1 << (deg + 1)) - 64'd1);
        v[deg] = 1'b1;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random(input int count);
    logic [gf2pau_pkg::OP_W-1:0] op;
    logic [gf2pau_pkg::OPND_W-1:0] a;
    logic [gf2pau_pkg::OPND_W-1:0] b;
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(99))
        0, 1, 2: op = OP_UNUSED;
        default: op = gf2pau_pkg::OP_W'($urandom_range(2));
      endcase
      a = pick_poly();
      b = pick_poly();
      // keep most divisions well formed
      if (op == gf2pau_pkg::OP_DIV && b == '0 && $urandom_range(3) != 0) begin
        b = $urandom() | gf2pau_pkg::OPND_W'(1) << $urandom_range(gf2pau_pkg::OPND_W - 1);
      end
      send_request(op, a, b);
      if (op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    board = new();
    cycle_count = 0;
    send_idle_pct = 14;
    recv_stall_pct = 55;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(gf2pau_pkg::OP_ADD, 32'h0, 32'h0);
    send_request(gf2pau_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send_request(gf2pau_pkg::OP_ADD, 32'hffff_ffff, 32'h0);
    send_request(gf2pau_pkg::OP_ADD, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_request(gf2pau_pkg::OP_MUL, 32'h0, 32'hffff_ffff);
    send_request(gf2pau_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
    send_request(gf2pau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_request(gf2pau_pkg::OP_MUL, 32'h1, 32'hffff_ffff);
    send_request(gf2pau_pkg::OP_MUL, 32'hffff_ffff, 32'h1);
    send_request(gf2pau_pkg::OP_MUL, 32'h3, 32'h3);
    // zero divisor
    send_request(gf2pau_pkg::OP_DIV, 32'hffff_ffff, 32'h0);
    send_request(gf2pau_pkg::OP_DIV, 32'h0, 32'h0);
    // dividend of lower degree than divisor, then higher and equal degrees
    send_request(gf2pau_pkg::OP_DIV, 32'h5, 32'h8000_0000);
    send_request(gf2pau_pkg::OP_DIV, 32'h0, 32'h7);
    send_request(gf2pau_pkg::OP_DIV, 32'hffff_ffff, 32'h1);
    send_request(gf2pau_pkg::OP_DIV, 32'hffff_ffff, 32'hffff_ffff);
    send_request(gf2pau_pkg::OP_DIV, 32'h8000_0000, 32'h3);
    send_request(gf2pau_pkg::OP_DIV, 32'h1234_5678, 32'h1234_5678);
    send_request(gf2pau_pkg::OP_DIV, 32'hffff_ffff, 32'h8000_0000);
    send_request(gf2pau_pkg::OP_DIV, 32'hdead_beef, 32'h11b);
    // unused op code gives an all-zero result
    send_request(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_UNUSED, 32'h0, 32'h0);

    run_random(ITEM_TARGET / 3);
    send_idle_pct <= 55;
    recv_stall_pct <= 14;
    run_random(ITEM_TARGET / 3);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    run_random(ITEM_TARGET - 2 * (ITEM_TARGET / 3));

    in_valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatch_count == 0 && board.awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
